@@ sv/matrix_times_stored_matrix_plus_error_unit_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the matrix times stored matrix plus error unit.
// ----------------------------------------------------------------------------
`ifndef MATRIX_TIMES_STORED_MATRIX_PLUS_ERROR_UNIT_ASSERT_SVH
`define MATRIX_TIMES_STORED_MATRIX_PLUS_ERROR_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MSTM_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mstm assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define MSTM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mstm assertion failed");

`endif

@@ sv/mstm_pkg.sv @@
// ----------------------------------------------------------------------------
// mstm_pkg
// Shared types, codes and default sizes of the matrix multiply-add unit.
// ----------------------------------------------------------------------------
package mstm_pkg;

    localparam int TYPE_W  = 2;
    localparam int INDEX_W = 10;
    localparam int COL_W   = 4;
    localparam int WORD_W  = 32;
    localparam int ROW_W   = 10;

    localparam int INNER_DIM_DEF  = 1024;
    localparam int OUT_COLS_DEF   = 12;
    localparam int OUTER_ROWS_DEF = 1024;

    localparam logic [TYPE_W-1:0] REQ_LOAD   = 2'd0;
    localparam logic [TYPE_W-1:0] REQ_PRESET = 2'd1;
    localparam logic [TYPE_W-1:0] REQ_STREAM = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MULT,
        ST_ACC,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic mul_en;
        logic acc_en;
        logic emit;
        logic clear;
    } ctrl_t;

endpackage

@@ sv/mstm_ram.sv @@
// ----------------------------------------------------------------------------
// mstm_ram
// Generic single-port synchronous RAM with a registered read.
// ----------------------------------------------------------------------------
module mstm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic             re,
    input  logic [AW-1:0]    addr,
    input  logic [WIDTH-1:0] wdata,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ sv/mstm_ctrl.sv @@
// ----------------------------------------------------------------------------
// mstm_ctrl
// Sequencer for streamed requests: read, multiply, accumulate, emit the row.
// ----------------------------------------------------------------------------
module mstm_ctrl #(
    parameter int OUT_COLS   = mstm_pkg::OUT_COLS_DEF,
    parameter int OUTER_ROWS = mstm_pkg::OUTER_ROWS_DEF,
    localparam int COL_CW = (OUT_COLS > 1) ? $clog2(OUT_COLS) : 1,
    localparam int ROW_CW = (OUTER_ROWS > 1) ? $clog2(OUTER_ROWS) : 1
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  stream_accept,
    input  logic                  row_end,
    input  logic                  in_range,
    output logic                  busy,
    output mstm_pkg::ctrl_t       ctl,
    output logic [COL_CW-1:0]     col_cnt,
    output logic [ROW_CW-1:0]     row_cnt
);

    import mstm_pkg::*;

    state_t             state_reg, state_next;
    logic [COL_CW-1:0]  col_reg, col_next;
    logic [ROW_CW-1:0]  row_reg, row_next;
    logic               end_reg, end_next;
    logic               hit_reg, hit_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            col_reg   <= '0;
            row_reg   <= '0;
            end_reg   <= 1'b0;
            hit_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            col_reg   <= col_next;
            row_reg   <= row_next;
            end_reg   <= end_next;
            hit_reg   <= hit_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        col_next   = col_reg;
        row_next   = row_reg;
        end_next   = end_reg;
        hit_next   = hit_reg;
        ctl        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (stream_accept)
                begin
                    end_next   = row_end;
                    hit_next   = in_range;
                    state_next = ST_MULT;
                end
            end
            ST_MULT:
            begin
                ctl.mul_en = 1'b1;
                state_next = ST_ACC;
            end
            ST_ACC:
            begin
                ctl.acc_en = hit_reg;
                state_next = end_reg ? ST_EMIT : ST_IDLE;
            end
            ST_EMIT:
            begin
                ctl.emit = 1'b1;
                if (col_reg == COL_CW'(OUT_COLS - 1))
                begin
                    ctl.clear  = 1'b1;
                    col_next   = '0;
                    state_next = ST_IDLE;
                    if (row_reg == ROW_CW'(OUTER_ROWS - 1))
                    begin
                        row_next = '0;
                    end
                    else
                    begin
                        row_next = row_reg + 1'b1;
                    end
                end
                else
                begin
                    col_next = col_reg + 1'b1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign busy    = (state_reg != ST_IDLE);
    assign col_cnt = col_reg;
    assign row_cnt = row_reg;

endmodule

@@ sv/matrix_times_stored_matrix_plus_error_unit.sv @@
// ----------------------------------------------------------------------------
// matrix_times_stored_matrix_plus_error_unit
// Computes X*Y + E modulo 2^32 against a stored matrix Y.
// ----------------------------------------------------------------------------
// A load or preset request leaves busy low, so a new request can start in
// the next cycle. A streamed element goes through the registered read of
// the column RAM banks, the parallel per-column multipliers and the addition
// of the products to the accumulators, with busy high until it is done. The
// element that ends a row then gives one result per cycle in column order,
// during which busy stays high. Results are shown for exactly one cycle
// with result_valid and cannot be held off, so the receiver must take
// every one as it comes. The stored matrix is not cleared by reset.
module matrix_times_stored_matrix_plus_error_unit #(
    parameter int INNER_DIM  = mstm_pkg::INNER_DIM_DEF,
    parameter int OUT_COLS   = mstm_pkg::OUT_COLS_DEF,
    parameter int OUTER_ROWS = mstm_pkg::OUTER_ROWS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [mstm_pkg::TYPE_W-1:0]  req_type,
    input  logic [mstm_pkg::INDEX_W-1:0] inner_index,
    input  logic [mstm_pkg::COL_W-1:0]   col_index,
    input  logic [mstm_pkg::WORD_W-1:0]  word_value,
    input  logic                         row_end,
    output logic                         result_valid,
    output logic [mstm_pkg::ROW_W-1:0]   result_row,
    output logic [mstm_pkg::COL_W-1:0]   result_col,
    output logic [mstm_pkg::WORD_W-1:0]  result_word,
    output logic                         result_last
);

    import mstm_pkg::*;

    localparam int INNER_AW = (INNER_DIM > 1) ? $clog2(INNER_DIM) : 1;
    localparam int COL_CW   = (OUT_COLS > 1) ? $clog2(OUT_COLS) : 1;
    localparam int ROW_CW   = (OUTER_ROWS > 1) ? $clog2(OUTER_ROWS) : 1;

    logic                accept;
    logic                load_accept;
    logic                preset_accept;
    logic                stream_accept;
    logic                in_range;
    logic [INNER_AW-1:0] ram_addr;
    ctrl_t               ctl;
    logic [COL_CW-1:0]   col_cnt;
    logic [ROW_CW-1:0]   row_cnt;

    logic [WORD_W-1:0]   bank_rdata [OUT_COLS];
    logic [WORD_W-1:0]   word_reg;
    logic [WORD_W-1:0]   prod_reg   [OUT_COLS];
    logic [WORD_W-1:0]   acc_reg    [OUT_COLS];
    logic [WORD_W-1:0]   acc_next   [OUT_COLS];

    assign accept        = start && !busy;
    assign load_accept   = accept && (req_type == REQ_LOAD);
    assign preset_accept = accept && (req_type == REQ_PRESET);
    assign stream_accept = accept && (req_type == REQ_STREAM);
    assign in_range      = (32'(inner_index) < 32'(INNER_DIM));
    assign ram_addr      = INNER_AW'(inner_index);

    mstm_ctrl #(
        .OUT_COLS   (OUT_COLS),
        .OUTER_ROWS (OUTER_ROWS)
    ) u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .stream_accept (stream_accept),
        .row_end       (row_end),
        .in_range      (in_range),
        .busy          (busy),
        .ctl           (ctl),
        .col_cnt       (col_cnt),
        .row_cnt       (row_cnt)
    );

    always_ff @(posedge clk)
    begin
        if (stream_accept)
        begin
            word_reg <= word_value;
        end
    end

    for (genvar k = 0; k < OUT_COLS; k++)
    begin : g_col
        logic bank_we;
        logic col_hit;

        assign col_hit = (32'(col_index) == 32'(k));
        assign bank_we = load_accept && in_range && col_hit;

        mstm_ram #(
            .WIDTH (WORD_W),
            .DEPTH (INNER_DIM)
        ) u_bank (
            .clk   (clk),
            .we    (bank_we),
            .re    (stream_accept),
            .addr  (ram_addr),
            .wdata (word_value),
            .rdata (bank_rdata[k])
        );

        always_ff @(posedge clk)
        begin
            if (ctl.mul_en)
            begin
                prod_reg[k] <= word_reg * bank_rdata[k];
            end
        end

        always_comb
        begin
            acc_next[k] = acc_reg[k];
            if (ctl.clear)
            begin
                acc_next[k] = '0;
            end
            else if (ctl.acc_en)
            begin
                acc_next[k] = acc_reg[k] + prod_reg[k];
            end
            else if (preset_accept && col_hit)
            begin
                acc_next[k] = word_value;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                acc_reg[k] <= '0;
            end
            else
            begin
                acc_reg[k] <= acc_next[k];
            end
        end
    end

    assign result_valid = ctl.emit;
    assign result_row   = ROW_W'(row_cnt);
    assign result_col   = COL_W'(col_cnt);
    assign result_word  = acc_reg[col_cnt];
    assign result_last  = ctl.emit && (col_cnt == COL_CW'(OUT_COLS - 1));

endmodule

@@ sv/mstm_checker.sv @@
// ----------------------------------------------------------------------------
// mstm_checker
// Port-level checks on request acceptance and the ordering of row results.
// ----------------------------------------------------------------------------
`include "matrix_times_stored_matrix_plus_error_unit_assert.svh"

module mstm_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         start,
    input logic                         busy,
    input logic [mstm_pkg::TYPE_W-1:0]  req_type,
    input logic                         result_valid,
    input logic [mstm_pkg::COL_W-1:0]   result_col,
    input logic                         result_last
);

    import mstm_pkg::*;

    // Results are only shown while the unit is busy with a row.
    `MSTM_ASSERT_SAME(a_result_while_busy, clk, rst_n, result_valid, busy)

    // A row's results come in consecutive cycles with rising column numbers.
    `MSTM_ASSERT_NEXT(a_results_back_to_back, clk, rst_n, result_valid && !result_last, result_valid && (result_col == COL_W'($past(result_col) + 1'b1)))

    // Nothing follows the last result of a row in the next cycle.
    `MSTM_ASSERT_NEXT(a_gap_after_last, clk, rst_n, result_valid && result_last, !result_valid)

    // A streamed request keeps the unit busy in the following cycle.
    `MSTM_ASSERT_NEXT(a_stream_busy, clk, rst_n, start && !busy && (req_type == REQ_STREAM), busy)

endmodule

bind matrix_times_stored_matrix_plus_error_unit mstm_checker u_mstm_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .req_type     (req_type),
    .result_valid (result_valid),
    .result_col   (result_col),
    .result_last  (result_last)
);

@@ dv/tb_matrix_times_stored_matrix_plus_error_unit.sv @@
// ----------------------------------------------------------------------------
// tb_matrix_times_stored_matrix_plus_error_unit
// Self-checking testbench of the matrix multiply-add unit. A driver issues
// queued requests in random bursts and gaps, a predictor keeps its own copy
// of the stored matrix, the column accumulators and the row counter, and a
// monitor compares every result word with the oldest expected one.
// ----------------------------------------------------------------------------
module tb_matrix_times_stored_matrix_plus_error_unit;

    import mstm_pkg::*;

    localparam int INNER_DIM    = INNER_DIM_DEF;
    localparam int OUT_COLS     = OUT_COLS_DEF;
    localparam int OUTER_ROWS   = OUTER_ROWS_DEF;
    localparam int DRAIN_CYCLES = 32;

    localparam logic [TYPE_W-1:0] REQ_UNUSED = 2'd3;

    typedef struct packed {
        logic [TYPE_W-1:0]  kind;
        logic [INDEX_W-1:0] inner;
        logic [COL_W-1:0]   col;
        logic [WORD_W-1:0]  word;
        logic               last;
    } request_t;

    typedef struct packed {
        logic [ROW_W-1:0]  row;
        logic [COL_W-1:0]  col;
        logic [WORD_W-1:0] word;
        logic              last;
    } product_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 start = 1'b0;
    logic                 busy;
    logic [TYPE_W-1:0]    req_type = '0;
    logic [INDEX_W-1:0]   inner_index = '0;
    logic [COL_W-1:0]     col_index = '0;
    logic [WORD_W-1:0]    word_value = '0;
    logic                 row_end = 1'b0;
    logic                 result_valid;
    logic [ROW_W-1:0]     result_row;
    logic [COL_W-1:0]     result_col;
    logic [WORD_W-1:0]    result_word;
    logic                 result_last;

    request_t             request_backlog[$];
    product_t             expected_products[$];
    request_t             in_flight;
    int                   gap_left = 0;
    int                   burst_left = 0;
    int                   error_count = 0;

    logic [WORD_W-1:0]    y_store [INNER_DIM*OUT_COLS];
    logic [WORD_W-1:0]    col_acc [OUT_COLS];
    int                   row_count = 0;

    logic [OUT_COLS-1:0]  row_written [INNER_DIM];
    int                   full_rows[$];

    matrix_times_stored_matrix_plus_error_unit #(
        .INNER_DIM  (INNER_DIM),
        .OUT_COLS   (OUT_COLS),
        .OUTER_ROWS (OUTER_ROWS)
    ) uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .req_type     (req_type),
        .inner_index  (inner_index),
        .col_index    (col_index),
        .word_value   (word_value),
        .row_end      (row_end),
        .result_valid (result_valid),
        .result_row   (result_row),
        .result_col   (result_col),
        .result_word  (result_word),
        .result_last  (result_last)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic logic [WORD_W-1:0] pick_word();
        case ($urandom_range(0, 7))
            0: return 32'h0000_0000;
            1: return 32'hFFFF_FFFF;
            2: return 32'h8000_0000;
            3: return 32'h0000_0001;
            default: return $urandom();
        endcase
    endfunction

    task automatic push_req(input logic [TYPE_W-1:0] kind, input int inner, input int col,
                            input logic [WORD_W-1:0] word, input bit last);
        request_t r;
        r.kind  = kind;
        r.inner = INDEX_W'(inner);
        r.col   = COL_W'(col);
        r.word  = word;
        r.last  = last;
        request_backlog.push_back(r);
        if (kind == REQ_LOAD && int'(r.col) < OUT_COLS && !(&row_written[r.inner]))
        begin
            row_written[r.inner][r.col] = 1'b1;
            if (&row_written[r.inner])
                full_rows.push_back(int'(r.inner));
        end
    endtask

    task automatic load_full_row(input int row);
        int k;
        for (k = 0; k < OUT_COLS; k++)
            push_req(REQ_LOAD, row, k, pick_word(), 1'($urandom_range(0, 1)));
    endtask

    // Only rows whose every column has been loaded are ever streamed.
    task automatic compute_row(input int n_elems, input bit with_presets);
        int j;
        if (with_presets)
            repeat ($urandom_range(1, 6))
                push_req(REQ_PRESET, $urandom_range(0, 1023), $urandom_range(0, 15),
                         pick_word(), 1'($urandom_range(0, 1)));
        for (j = 0; j < n_elems; j++)
        begin
            if ($urandom_range(0, 9) == 0)
                push_req(REQ_UNUSED, $urandom_range(0, 1023), $urandom_range(0, 15),
                         $urandom(), 1'($urandom_range(0, 1)));
            push_req(REQ_STREAM, full_rows[$urandom_range(0, full_rows.size() - 1)],
                     $urandom_range(0, 15), pick_word(), j == n_elems - 1);
        end
    endtask

    task automatic predict_products(input request_t r);
        product_t p;
        int       k;
        case (r.kind)
            REQ_LOAD:
                if (int'(r.inner) < INNER_DIM && int'(r.col) < OUT_COLS)
                    y_store[int'(r.inner) * OUT_COLS + int'(r.col)] = r.word;
            REQ_PRESET:
                if (int'(r.col) < OUT_COLS)
                    col_acc[r.col] = r.word;
            REQ_STREAM:
            begin
                if (int'(r.inner) < INNER_DIM)
                    for (k = 0; k < OUT_COLS; k++)
                        col_acc[k] = col_acc[k] + r.word * y_store[int'(r.inner) * OUT_COLS + k];
                if (r.last)
                begin
                    for (k = 0; k < OUT_COLS; k++)
                    begin
                        p.row  = ROW_W'(row_count);
                        p.col  = COL_W'(k);
                        p.word = col_acc[k];
                        p.last = (k == OUT_COLS - 1);
                        expected_products.push_back(p);
                        col_acc[k] = '0;
                    end
                    row_count = (row_count + 1 >= OUTER_ROWS) ? 0 : row_count + 1;
                end
            end
            default: ;
        endcase
    endtask

    task automatic check_field(input string name, input logic [WORD_W-1:0] want,
                               input logic [WORD_W-1:0] got);
        if (got !== want)
        begin
            $error("%s mismatch: expected %0h, actual %0h", name, want, got);
            error_count++;
        end
    endtask

    always @(posedge clk)
    begin : request_driver
        bit fire;
        if (rst_n)
        begin
            fire = start && !busy;
            if (fire)
            begin
                predict_products(in_flight);
                if (burst_left > 0)
                    burst_left--;
            end
            if (!start || fire)
            begin
                if (burst_left == 0)
                begin
                    burst_left = $urandom_range(1, 24);
                    gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
                end
                if (gap_left > 0)
                begin
                    gap_left--;
                    start <= 1'b0;
                end
                else if (request_backlog.size() != 0)
                begin
                    in_flight = request_backlog.pop_front();
                    req_type    <= in_flight.kind;
                    inner_index <= in_flight.inner;
                    col_index   <= in_flight.col;
                    word_value  <= in_flight.word;
                    row_end     <= in_flight.last;
                    start       <= 1'b1;
                end
                else
                    start <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin : result_monitor
        product_t want;
        if (rst_n && result_valid)
        begin
            if (expected_products.size() == 0)
            begin
                $error("unexpected result: row %0d col %0d word %0h", result_row,
                       result_col, result_word);
                error_count++;
            end
            else
            begin
                want = expected_products.pop_front();
                check_field("result_row", WORD_W'(want.row), WORD_W'(result_row));
                check_field("result_col", WORD_W'(want.col), WORD_W'(result_col));
                check_field("result_word", want.word, result_word);
                check_field("result_last", WORD_W'(want.last), WORD_W'(result_last));
            end
        end
    end

    initial
    begin
        int i;
        for (i = 0; i < INNER_DIM; i++)
            row_written[i] = '0;
        for (i = 0; i < OUT_COLS; i++)
            col_acc[i] = '0;

        // Directed requests: extreme values, ignored requests and a row with no presets.
        load_full_row(1023);
        push_req(REQ_LOAD, 1023, 0, 32'hFFFF_FFFF, 1'b1);
        push_req(REQ_LOAD, 1023, 11, 32'h0000_0000, 1'b0);
        push_req(REQ_LOAD, 1023, 15, 32'h1234_5678, 1'b0);
        push_req(REQ_LOAD, 0, 12, 32'hFFFF_FFFF, 1'b0);
        push_req(REQ_UNUSED, 1023, 15, 32'hFFFF_FFFF, 1'b1);
        push_req(REQ_PRESET, 0, 0, 32'hFFFF_FFFF, 1'b1);
        push_req(REQ_PRESET, 1023, 11, 32'h8000_0000, 1'b0);
        push_req(REQ_PRESET, 0, 13, 32'h0000_0001, 1'b0);
        push_req(REQ_STREAM, 1023, 0, 32'hFFFF_FFFF, 1'b0);
        push_req(REQ_STREAM, 1023, 15, 32'h8000_0001, 1'b1);
        push_req(REQ_STREAM, 1023, 0, 32'h0000_0001, 1'b1);

        // Random rows of well-formed requests with some noise in between.
        load_full_row(0);
        repeat (3)
            load_full_row($urandom_range(1, 1022));
        while (request_backlog.size() < 160)
        begin
            case ($urandom_range(0, 9))
                0: push_req(REQ_LOAD, $urandom_range(0, 1023), $urandom_range(0, 15),
                            $urandom(), 1'($urandom_range(0, 1)));
                1: push_req(REQ_LOAD, full_rows[$urandom_range(0, full_rows.size() - 1)],
                            $urandom_range(0, 15), pick_word(), 1'($urandom_range(0, 1)));
                2: load_full_row($urandom_range(0, 1023));
                default: compute_row($urandom_range(1, 4), $urandom_range(0, 3) != 0);
            endcase
        end

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        while (request_backlog.size() != 0 || start || expected_products.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (error_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("Verification failed");
        $finish;
    end

endmodule
